// ===== sv/union_find_maze_carver_unit_assert.svh =====
// assertion macros for the maze carver
`ifndef UNION_FIND_MAZE_CARVER_UNIT_ASSERT_SVH
`define UNION_FIND_MAZE_CARVER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define UFMC_ASSERT_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define UFMC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define UFMC_ASSERT_IMPLY(lbl, ante, cons, msg)
`define UFMC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ===== sv/ufmc_pkg.sv =====
package ufmc_pkg;

	localparam int CELL_W       = 11;
	localparam int CFG_W        = 6;
	localparam int WALL_W       = 13;
	localparam int DEF_MAX_SIDE = 32;
	localparam logic [CFG_W-1:0] GRID_SIDE_RESET = CFG_W'(8);

	typedef enum logic [1:0] {
		OC_NONE      = 2'd0,
		OC_JOINED    = 2'd1,
		OC_JOINED_NOW = 2'd2,
		OC_RANGE     = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_GEOM,
		ST_ISSUE,
		ST_WALK,
		ST_LINK
	} ctrl_st_t;

	typedef enum logic [1:0] {
		PH_A,
		PH_B,
		PH_FIRST,
		PH_LAST
	} phase_t;

	typedef struct packed {
		logic              nb;
		logic [WALL_W-1:0] pos;
	} geom_res_t;

endpackage

// ===== sv/ufmc_parent_mem.sv =====
module ufmc_parent_mem import ufmc_pkg::*; #(
	parameter int DEPTH = DEF_MAX_SIDE * DEF_MAX_SIDE,
	parameter int AW    = $clog2(DEF_MAX_SIDE * DEF_MAX_SIDE)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              re,
	input  logic [AW-1:0]     raddr,
	output logic [CELL_W-1:0] rdata,
	input  logic              we,
	input  logic [AW-1:0]     waddr,
	input  logic [CELL_W-1:0] wdata,
	output logic              clearing
);

	logic [CELL_W-1:0] mem [DEPTH];
	logic              clearing_q;
	logic [AW-1:0]     clr_q;
	logic              we_eff;
	logic [AW-1:0]     waddr_eff;
	logic [CELL_W-1:0] wdata_eff;

	// clearing pass marks every entry as root
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_q      <= '0;
		end else if (clearing_q) begin
			clr_q <= clr_q + AW'(1);
			if (clr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	always_comb begin
		we_eff    = clearing_q | we;
		waddr_eff = clearing_q ? clr_q : waddr;
		wdata_eff = clearing_q ? '0 : wdata;
	end

	always_ff @(posedge clk) begin
		if (we_eff) begin
			mem[waddr_eff] <= wdata_eff;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

	assign clearing = clearing_q;

endmodule

// ===== sv/ufmc_geom.sv =====
module ufmc_geom import ufmc_pkg::*; #(
	parameter int SW = $clog2(DEF_MAX_SIDE + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [CELL_W-1:0] cell_a,
	input  logic [CELL_W-1:0] cell_b,
	input  logic [SW-1:0]     side,
	output logic              done,
	output geom_res_t         res
);

	localparam int CNT_W = $clog2(CELL_W + 1);
	localparam int MW    = SW + 2;

	logic              run_q;
	logic              fin_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CELL_W-1:0] dvd_q;
	logic [CELL_W-1:0] quo_q;
	logic [SW:0]       rem_q;
	logic [CELL_W-1:0] x_q;
	logic [CELL_W-1:0] y_q;

	logic [SW:0]       trial;
	logic              qbit;

	logic              hr, hl, vd, vu;
	logic [SW-1:0]     rx, cx;
	logic [MW-1:0]     w, rx2, cx2, fac, addt;

	logic              vld_s1;
	logic              nb_s1;
	logic [2*MW-1:0]   prod_s1;
	logic [MW-1:0]     add_s1;

	logic              vld_s2;
	geom_res_t         res_s2;

	// restoring divide of cell_a - 1 by the side, one quotient bit per cycle
	always_comb begin
		trial = {rem_q[SW-1:0], dvd_q[CELL_W-1]};
		qbit  = (trial >= {1'b0, side});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			cnt_q  <= '0;
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			fin_q  <= 1'b0;
			vld_s1 <= fin_q;
			vld_s2 <= vld_s1;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CNT_W'(CELL_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					run_q <= 1'b0;
					fin_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= cell_a;
			y_q   <= cell_b;
			dvd_q <= cell_a - CELL_W'(1);
			quo_q <= '0;
			rem_q <= '0;
		end else if (run_q) begin
			dvd_q <= {dvd_q[CELL_W-2:0], 1'b0};
			quo_q <= {quo_q[CELL_W-2:0], qbit};
			rem_q <= qbit ? (trial - {1'b0, side}) : trial;
		end
	end

	// neighbor test and wall position terms
	always_comb begin
		rx  = quo_q[SW-1:0];
		cx  = rem_q[SW-1:0];
		w   = {1'b0, side, 1'b1};
		rx2 = {1'b0, rx, 1'b0};
		cx2 = {1'b0, cx, 1'b0};
		hr  = (({1'b0, x_q} + (CELL_W + 1)'(1)) == {1'b0, y_q}) && (cx != side - SW'(1));
		hl  = (({1'b0, y_q} + (CELL_W + 1)'(1)) == {1'b0, x_q}) && (cx != '0);
		vd  = (({1'b0, x_q} + (CELL_W + 1)'(side)) == {1'b0, y_q});
		vu  = (({1'b0, y_q} + (CELL_W + 1)'(side)) == {1'b0, x_q});
		fac  = rx2;
		addt = cx2 + MW'(1);
		if (hr) begin
			fac  = rx2 + MW'(1);
			addt = cx2 + MW'(2);
		end else if (hl) begin
			fac  = rx2 + MW'(1);
			addt = cx2;
		end else if (vd) begin
			fac  = rx2 + MW'(2);
			addt = cx2 + MW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (fin_q) begin
			nb_s1   <= hr | hl | vd | vu;
			prod_s1 <= w * fac;
			add_s1  <= addt;
		end
		if (vld_s1) begin
			res_s2.nb  <= nb_s1;
			res_s2.pos <= WALL_W'(prod_s1 + (2 * MW)'(add_s1));
		end
	end

	assign done = vld_s2;
	assign res  = res_s2;

endmodule

// ===== sv/union_find_maze_carver_unit.sv =====
// channel   signals                                  handshake
// input     start, busy, cell_a, cell_b              beat when start high and busy low
// config    cfg_valid, cfg_ready, cfg_data           beat when valid and ready high
// result    done, outcome, wall_index,               one-cycle strobe on done,
//           start_end_joined                         receiver cannot stall
//
// steps per item: an accept, then the divide and wall position when both cells are in range
//   and distinct, then one root walk each for cell_a and cell_b (neighbors only), cell 1 and
//   the last cell, with a link write when the two roots of a neighbor pair differ
// the root walks go through the parent memory's single read port, one link per cycle
// after reset a clearing pass over all MAX_SIDE * MAX_SIDE entries holds busy high
// cfg_ready is always high; the host must write the register only while busy is low, the block does not enforce it
`include "union_find_maze_carver_unit_assert.svh"

module union_find_maze_carver_unit import ufmc_pkg::*; #(
	parameter int MAX_SIDE = DEF_MAX_SIDE
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [CELL_W-1:0] cell_a,
	input  logic [CELL_W-1:0] cell_b,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_W-1:0]  cfg_data,
	output logic              done,
	output logic [1:0]        outcome,
	output logic [WALL_W-1:0] wall_index,
	output logic              start_end_joined
);

	localparam int CELLS = MAX_SIDE * MAX_SIDE;
	localparam int AW    = $clog2(CELLS);
	localparam int SW    = $clog2(MAX_SIDE + 1);
	localparam int CMP_W = (SW > CFG_W) ? SW : CFG_W;
	localparam int PW    = (2 * SW > CELL_W) ? 2 * SW : CELL_W;

	logic [CFG_W-1:0]  grid_side_q;
	logic [CMP_W-1:0]  gs_ext;
	logic [SW-1:0]     side;
	logic [PW-1:0]     last_cell;

	ctrl_st_t          state_q, state_d;
	phase_t            phase_q;
	outcome_t          outcome_q;
	logic [WALL_W-1:0] wall_q;
	logic              done_q;
	logic              joined_q;
	logic [CELL_W-1:0] x_q, y_q;
	logic [PW-1:0]     cur_q;
	logic [PW-1:0]     root_a_q, root_b_q, root_f_q;

	logic              accept;
	logic              out_of_range;
	logic              same_cell;
	logic [PW-1:0]     walk_start;
	logic [PW-1:0]     parent;
	logic              at_root;

	logic              geom_start;
	logic              geom_done;
	geom_res_t         geom_res;

	logic              mem_re;
	logic [AW-1:0]     mem_raddr;
	logic [CELL_W-1:0] mem_rdata;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [CELL_W-1:0] mem_wdata;
	logic              mem_clearing;

	// effective side, clamped to 2 .. MAX_SIDE
	always_comb begin
		gs_ext = CMP_W'(grid_side_q);
		if (gs_ext < CMP_W'(2)) begin
			side = SW'(2);
		end else if (gs_ext > CMP_W'(MAX_SIDE)) begin
			side = SW'(MAX_SIDE);
		end else begin
			side = SW'(gs_ext);
		end
		last_cell = PW'(side) * PW'(side);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= GRID_SIDE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			grid_side_q <= cfg_data;
		end
	end

	assign cfg_ready = 1'b1;
	assign busy      = mem_clearing || (state_q != ST_IDLE);
	assign accept    = start && !busy;

	always_comb begin
		out_of_range = (cell_a == '0) || (cell_b == '0) ||
			(PW'(cell_a) > last_cell) || (PW'(cell_b) > last_cell);
		same_cell    = (cell_a == cell_b);
		parent       = PW'(mem_rdata);
		at_root      = (mem_rdata == '0);
		case (phase_q)
			PH_A:     walk_start = PW'(x_q);
			PH_B:     walk_start = PW'(y_q);
			PH_FIRST: walk_start = PW'(1);
			PH_LAST:  walk_start = last_cell;
			default:  walk_start = PW'(1);
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					state_d = (out_of_range || same_cell) ? ST_ISSUE : ST_GEOM;
				end
			end
			ST_GEOM: begin
				if (geom_done) begin
					state_d = ST_ISSUE;
				end
			end
			ST_ISSUE: state_d = ST_WALK;
			ST_WALK: begin
				if (at_root) begin
					case (phase_q)
						PH_B:    state_d = (cur_q == root_a_q) ? ST_ISSUE : ST_LINK;
						PH_LAST: state_d = ST_IDLE;
						default: state_d = ST_ISSUE;
					endcase
				end
			end
			ST_LINK: state_d = ST_ISSUE;
			default: state_d = ST_IDLE;
		endcase
	end

	// memory and unit controls
	always_comb begin
		geom_start = 1'b0;
		mem_re     = 1'b0;
		mem_raddr  = AW'(walk_start - PW'(1));
		mem_we     = 1'b0;
		mem_waddr  = AW'(root_b_q - PW'(1));
		mem_wdata  = CELL_W'(root_a_q);
		case (state_q)
			ST_IDLE:  geom_start = accept && !out_of_range && !same_cell;
			ST_ISSUE: mem_re = 1'b1;
			ST_WALK: begin
				if (!at_root) begin
					mem_re    = 1'b1;
					mem_raddr = AW'(parent - PW'(1));
				end
			end
			ST_LINK:  mem_we = 1'b1;
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_WALK) && at_root && (phase_q == PH_LAST);
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					x_q       <= cell_a;
					y_q       <= cell_b;
					wall_q    <= '0;
					outcome_q <= out_of_range ? OC_RANGE : OC_NONE;
					phase_q   <= PH_FIRST;
				end
			end
			ST_GEOM: begin
				if (geom_done && geom_res.nb) begin
					phase_q <= PH_A;
				end
			end
			ST_ISSUE: cur_q <= walk_start;
			ST_WALK: begin
				if (!at_root) begin
					cur_q <= parent;
				end else begin
					case (phase_q)
						PH_A: begin
							root_a_q <= cur_q;
							phase_q  <= PH_B;
						end
						PH_B: begin
							root_b_q <= cur_q;
							if (cur_q == root_a_q) begin
								outcome_q <= OC_JOINED;
								phase_q   <= PH_FIRST;
							end
						end
						PH_FIRST: begin
							root_f_q <= cur_q;
							phase_q  <= PH_LAST;
						end
						default: joined_q <= (root_f_q == cur_q);
					endcase
				end
			end
			ST_LINK: begin
				outcome_q <= OC_JOINED_NOW;
				wall_q    <= geom_res.pos;
				phase_q   <= PH_FIRST;
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	ufmc_geom #(
		.SW(SW)
	) u_geom (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (geom_start),
		.cell_a (cell_a),
		.cell_b (cell_b),
		.side   (side),
		.done   (geom_done),
		.res    (geom_res)
	);

	ufmc_parent_mem #(
		.DEPTH(CELLS),
		.AW   (AW)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.re       (mem_re),
		.raddr    (mem_raddr),
		.rdata    (mem_rdata),
		.we       (mem_we),
		.waddr    (mem_waddr),
		.wdata    (mem_wdata),
		.clearing (mem_clearing)
	);

	assign done             = done_q;
	assign outcome          = outcome_q;
	assign wall_index       = wall_q;
	assign start_end_joined = joined_q;

	`UFMC_ASSERT_NEXT(a_strobe_single, done_q, !done_q, "result strobe held longer than one cycle")
	`UFMC_ASSERT_IMPLY(a_wall_zero, done_q && (outcome_q != OC_JOINED_NOW), wall_q == '0, "wall reported without a join")
	`UFMC_ASSERT_NEXT(a_busy_after_beat, accept, busy, "busy low after an input beat")
	`UFMC_ASSERT_IMPLY(a_no_rw_clash, mem_re && mem_we, mem_raddr != mem_waddr, "read and write of one entry in one cycle")
	`UFMC_ASSERT_IMPLY(a_no_link_in_clear, mem_we, !mem_clearing, "link written during clearing pass")

endmodule
